>>> hw/rtl/root_directory_record_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Root directory record parser - assertion macros
// Clocked property shorthands used by the asserting top-level file.
// ----------------------------------------------------------------------------
`ifndef ROOT_DIRECTORY_RECORD_PARSER_TOP_MACROS_SVH
`define ROOT_DIRECTORY_RECORD_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RDRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RDRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/rdrp_pkg.sv
// ----------------------------------------------------------------------------
// Root directory record parser - package
// Shared types, codes and sizing constants.
// ----------------------------------------------------------------------------
package rdrp_pkg;

	localparam int KEY_BYTES   = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W   = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_SIG  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_SIG = 1'b1;

	typedef enum logic [3:0] {
		PH_SIG  = 4'd0,
		PH_ACNT = 4'd1,
		PH_AKEY = 4'd2,
		PH_AIDX = 4'd3,
		PH_ICNT = 4'd4,
		PH_IKEY = 4'd5,
		PH_IIDX = 4'd6,
		PH_ISUB = 4'd7,
		PH_NCNT = 4'd8,
		PH_NKEY = 4'd9,
		PH_NAME = 4'd10
	} phase_t;

	// byte classes beyond the phase codes
	localparam logic [3:0] CL_NAME_END = 4'd11;
	localparam logic [3:0] CL_IGNORED  = 4'd12;

	typedef enum logic [1:0] {
		ST_BUSY   = 2'd0,
		ST_DONE   = 2'd1,
		ST_BADSIG = 2'd2,
		ST_TRUNC  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       blob_end;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  byte_class;
		logic [3:0]  byte_position;
		logic [31:0] word_value;
		logic        word_valid;
		logic [31:0] entry_number;
		logic [1:0]  parse_status;
		logic [7:0]  byte_echo;
	} out_item_t;

	// word handed from the front to the parser
	typedef struct packed {
		in_item_t item;
		logic     zero_byte;
	} fe_item_t;

	// parser status seen by the top level
	typedef struct packed {
		phase_t  phase;
		status_t status;
	} stat_t;

endpackage

>>> hw/rtl/rdrp_queue.sv
// ----------------------------------------------------------------------------
// Root directory record parser - word queue
// Small first-in first-out register queue; push and pop may share the same cycle.
// ----------------------------------------------------------------------------
module rdrp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic             rd_en;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_en = pop & ~empty;
	assign wr_en = push & (~full | rd_en);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/rdrp_front.sv
// ----------------------------------------------------------------------------
// Root directory record parser - front end
// Accept blob bytes, tag terminator bytes, and buffer them for the parser.
// ----------------------------------------------------------------------------
module rdrp_front #(
	parameter int DEPTH = rdrp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rdrp_pkg::in_item_t item,
	output logic               full,
	output logic               fe_valid,
	output rdrp_pkg::fe_item_t fe_item,
	input  logic               fe_take
);

	localparam int FE_W = $bits(rdrp_pkg::fe_item_t);

	rdrp_pkg::fe_item_t tagged_item;
	logic [FE_W-1:0]    head_bits;
	logic               fe_empty;

	// tag the name terminator up front
	always_comb begin
		tagged_item.item      = item;
		tagged_item.zero_byte = (item.data_byte == 8'd0);
	end

	// take a word only when the port shows room, even if the parser frees a
	// slot in the same cycle
	rdrp_queue #(
		.WIDTH(FE_W),
		.DEPTH(DEPTH)
	) u_in_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push & ~full),
		.wdata (tagged_item),
		.full  (full),
		.pop   (fe_take),
		.rdata (head_bits),
		.empty (fe_empty)
	);

	assign fe_valid = ~fe_empty;
	assign fe_item  = rdrp_pkg::fe_item_t'(head_bits);

endmodule

>>> hw/rtl/rdrp_parser.sv
// ----------------------------------------------------------------------------
// Root directory record parser - back end
// Walk the record layout one byte per cycle unless stalled; a result per byte.
// ----------------------------------------------------------------------------
module rdrp_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [rdrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          fe_valid,
	input  rdrp_pkg::fe_item_t            fe_item,
	output logic                          fe_take,
	input  logic                          out_room,
	output logic                          res_valid,
	output rdrp_pkg::out_item_t           res,
	output rdrp_pkg::stat_t               stat
);

	logic [31:0]       dir_sig_q;
	logic [31:0]       root_sig_q;
	rdrp_pkg::phase_t  phase_q;
	rdrp_pkg::phase_t  phase_d;
	logic [4:0]        fp_q;
	logic [4:0]        fp_d;
	logic [31:0]       shift_q;
	logic [31:0]       shift_d;
	logic [31:0]       left_q;
	logic [31:0]       left_d;
	logic [31:0]       index_q;
	logic [31:0]       index_d;
	rdrp_pkg::status_t status_q;
	rdrp_pkg::status_t status_d;

	logic [7:0]  b;
	logic [31:0] shift_new;
	logic [5:0]  fp_inc;
	logic [31:0] left_dec;
	logic [31:0] index_inc;
	logic        word_fin;
	logic        busy;

	assign b         = fe_item.item.data_byte;
	assign shift_new = {b, shift_q[31:8]};
	assign fp_inc    = {1'b0, fp_q} + 6'd1;
	assign left_dec  = left_q - 32'd1;
	assign index_inc = index_q + 32'd1;
	assign word_fin  = (fp_inc >= 6'd4);
	assign busy      = (status_q == rdrp_pkg::ST_BUSY);

	assign fe_take   = fe_valid & out_room;
	assign res_valid = fe_take;
	assign stat      = '{phase: phase_q, status: status_q};

	// next state
	always_comb begin
		phase_d  = phase_q;
		fp_d     = fp_q;
		shift_d  = shift_q;
		left_d   = left_q;
		index_d  = index_q;
		status_d = status_q;
		if (busy) begin
			case (phase_q)
				rdrp_pkg::PH_AKEY, rdrp_pkg::PH_IKEY, rdrp_pkg::PH_NKEY: begin
					fp_d = fp_inc[4:0];
					if (fp_inc >= 6'(rdrp_pkg::KEY_BYTES)) begin
						fp_d = '0;
						if (phase_q == rdrp_pkg::PH_AKEY) begin
							phase_d = rdrp_pkg::PH_AIDX;
						end else if (phase_q == rdrp_pkg::PH_IKEY) begin
							phase_d = rdrp_pkg::PH_IIDX;
						end else begin
							phase_d = rdrp_pkg::PH_NAME;
						end
					end
				end
				rdrp_pkg::PH_NAME: begin
					if (fe_item.zero_byte) begin
						fp_d    = '0;
						left_d  = left_dec;
						index_d = index_inc;
						if (left_dec != '0) begin
							phase_d = rdrp_pkg::PH_NKEY;
						end else begin
							status_d = rdrp_pkg::ST_DONE;
						end
					end else if (fp_q < 5'd31) begin
						fp_d = fp_inc[4:0];
					end
				end
				default: begin
					shift_d = shift_new;
					fp_d    = fp_inc[4:0];
					if (word_fin) begin
						fp_d    = '0;
						shift_d = '0;
						case (phase_q)
							rdrp_pkg::PH_SIG: begin
								if (shift_new == dir_sig_q) begin
									phase_d = rdrp_pkg::PH_ACNT;
								end else if (shift_new == root_sig_q) begin
									phase_d = rdrp_pkg::PH_NCNT;
								end else begin
									status_d = rdrp_pkg::ST_BADSIG;
								end
							end
							rdrp_pkg::PH_ACNT: begin
								left_d  = shift_new;
								index_d = '0;
								phase_d = (shift_new != '0) ? rdrp_pkg::PH_AKEY
								                            : rdrp_pkg::PH_ICNT;
							end
							rdrp_pkg::PH_AIDX: begin
								left_d  = left_dec;
								index_d = index_inc;
								phase_d = (left_dec != '0) ? rdrp_pkg::PH_AKEY
								                           : rdrp_pkg::PH_ICNT;
							end
							rdrp_pkg::PH_ICNT: begin
								left_d  = shift_new;
								index_d = '0;
								phase_d = (shift_new != '0) ? rdrp_pkg::PH_IKEY
								                            : rdrp_pkg::PH_NCNT;
							end
							rdrp_pkg::PH_IIDX: begin
								phase_d = rdrp_pkg::PH_ISUB;
							end
							rdrp_pkg::PH_ISUB: begin
								left_d  = left_dec;
								index_d = index_inc;
								phase_d = (left_dec != '0) ? rdrp_pkg::PH_IKEY
								                           : rdrp_pkg::PH_NCNT;
							end
							rdrp_pkg::PH_NCNT: begin
								left_d  = shift_new;
								index_d = '0;
								phase_d = (shift_new != '0) ? rdrp_pkg::PH_NKEY
								                            : rdrp_pkg::PH_NCNT;
								if (shift_new == '0) begin
									status_d = rdrp_pkg::ST_DONE;
								end
							end
							default: begin
							end
						endcase
					end
				end
			endcase
			if (fe_item.item.blob_end && status_d == rdrp_pkg::ST_BUSY) begin
				status_d = rdrp_pkg::ST_TRUNC;
			end
		end
	end

	// result word
	always_comb begin
		res.byte_class    = rdrp_pkg::CL_IGNORED;
		res.byte_position = '0;
		res.word_value    = '0;
		res.word_valid    = 1'b0;
		res.entry_number  = '0;
		res.parse_status  = status_d;
		res.byte_echo     = b;
		if (busy) begin
			res.byte_class = phase_q;
			case (phase_q)
				rdrp_pkg::PH_SIG, rdrp_pkg::PH_ACNT, rdrp_pkg::PH_ICNT,
				rdrp_pkg::PH_NCNT: begin
					res.entry_number = '0;
				end
				default: begin
					res.entry_number = index_q;
				end
			endcase
			case (phase_q)
				rdrp_pkg::PH_AKEY, rdrp_pkg::PH_IKEY, rdrp_pkg::PH_NKEY: begin
					res.byte_position = fp_q[3:0];
				end
				rdrp_pkg::PH_NAME: begin
					res.byte_position = (fp_q > 5'd15) ? 4'd15 : fp_q[3:0];
					if (fe_item.zero_byte) begin
						res.byte_class = rdrp_pkg::CL_NAME_END;
					end
				end
				default: begin
					res.byte_position = {2'b00, fp_q[1:0]};
					if (word_fin) begin
						res.word_value = shift_new;
						res.word_valid = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_sig_q  <= '0;
			root_sig_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == rdrp_pkg::CFG_DIR_SIG) begin
				dir_sig_q <= cfg_data;
			end
			if (cfg_index == rdrp_pkg::CFG_ROOT_SIG) begin
				root_sig_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rdrp_pkg::PH_SIG;
			fp_q     <= '0;
			shift_q  <= '0;
			left_q   <= '0;
			index_q  <= '0;
			status_q <= rdrp_pkg::ST_BUSY;
		end else if (fe_take) begin
			phase_q  <= phase_d;
			fp_q     <= fp_d;
			shift_q  <= shift_d;
			left_q   <= left_d;
			index_q  <= index_d;
			status_q <= status_d;
		end
	end

endmodule

>>> hw/rtl/root_directory_record_parser_top.sv
// ----------------------------------------------------------------------------
// Root directory record parser - top level
// Byte-serial parser of directory blobs with queue ports on both sides.
// ----------------------------------------------------------------------------
// Path: a pushed byte is held in the front queue, and the parser writes its
//   result into the result queue when it takes the byte.
// Throughput: one byte per cycle while the result queue has room, since the
//   parser updates its phase, position, shift and record counters per byte.
// Reset: arst_n clears both queues, the signature registers to zero and
//   the parser to expecting signature with status in progress.
// ----------------------------------------------------------------------------
`include "root_directory_record_parser_top_macros.svh"

module root_directory_record_parser_top #(
	parameter int IN_DEPTH  = rdrp_pkg::QUEUE_DEPTH,
	parameter int OUT_DEPTH = rdrp_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// byte input queue side
	input  logic                           push,
	input  rdrp_pkg::in_item_t             item,
	output logic                           full,
	// result queue side
	output logic                           empty,
	input  logic                           pop,
	output rdrp_pkg::out_item_t            result,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rdrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int OUT_W = $bits(rdrp_pkg::out_item_t);

	logic                fe_valid;
	rdrp_pkg::fe_item_t  fe_item;
	logic                fe_take;
	logic                out_full;
	logic                out_room;
	logic                res_valid;
	rdrp_pkg::out_item_t res;
	rdrp_pkg::stat_t     stat;
	logic [OUT_W-1:0]    out_bits;

	// Registers are to be written only while idle; the block does not enforce this, so take every write at once.
	assign cfg_ready = 1'b1;

	// Front: accept bytes and tag them; stalls only when its queue is full.
	rdrp_front #(
		.DEPTH(IN_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.fe_valid(fe_valid),
		.fe_item (fe_item),
		.fe_take (fe_take)
	);

	// The parser may write into a full result queue when a pop frees a slot
	// in the same cycle, which keeps the stream moving at one byte a cycle.
	assign out_room = ~out_full | (pop & ~empty);

	// Back: advance the record layout by one byte per taken word.
	rdrp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.fe_valid (fe_valid),
		.fe_item  (fe_item),
		.fe_take  (fe_take),
		.out_room (out_room),
		.res_valid(res_valid),
		.res      (res),
		.stat     (stat)
	);

	// Result queue: hold finished results until the consumer pops them.
	rdrp_queue #(
		.WIDTH(OUT_W),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_valid),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_bits),
		.empty (empty)
	);

	assign result = rdrp_pkg::out_item_t'(out_bits);

	// A word completes only on the fourth byte of its field.
	`RDRP_ASSERT_NOW(a_word_on_last_byte, clk, arst_n, res_valid && res.word_valid, res.byte_position == 4'd3, "word reported off the last field byte")

	// Nothing leaks into word_value without a completed word.
	`RDRP_ASSERT_NOW(a_word_value_clean, clk, arst_n, res_valid && !res.word_valid, res.word_value == 32'd0, "word value set without word valid")

	// A final status sticks until reset.
	`RDRP_ASSERT_NEXT(a_status_sticky, clk, arst_n, stat.status != rdrp_pkg::ST_BUSY, stat.status == $past(stat.status), "final status changed")

	// Once the parse is over every further byte is ignored.
	`RDRP_ASSERT_NOW(a_ignored_after_final, clk, arst_n, res_valid && stat.status != rdrp_pkg::ST_BUSY, res.byte_class == rdrp_pkg::CL_IGNORED, "byte classified after final status")

endmodule
